FILE: design/bsdg_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the brick scatter descriptor generator.
// No dependencies; every other file of the block imports this package.
package bsdg_pkg;

    localparam int POS_W      = 6;
    localparam int VOL_W      = 17;
    localparam int DIM_W      = 11;
    localparam int CNT_W      = 10;
    localparam int DEST_W     = 50;
    localparam int BYTES_W    = 13;
    localparam int SRC_W      = 32;
    localparam int REG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    // Register indexes on the configuration port
    localparam logic [REG_IDX_W-1:0] REG_BRICK_POS_X   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_BRICK_POS_Y   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_BRICK_POS_Z   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_VOLUME_WIDTH  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_VOLUME_HEIGHT = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_BRICK_WIDTH   = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_BRICK_HEIGHT  = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_BRICK_DEPTH   = 3'd7;

    // Configuration as seen by the datapath, brick sizes and positions saturated
    typedef struct packed {
        logic [POS_W-1:0] pos_x;
        logic [POS_W-1:0] pos_y;
        logic [POS_W-1:0] pos_z;
        logic [VOL_W-1:0] vol_w;
        logic [VOL_W-1:0] vol_h;
        logic [DIM_W-1:0] bw;
        logic [DIM_W-1:0] bh;
        logic [DIM_W-1:0] bd;
    } cfg_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;
        logic step1;
        logic step2;
        logic load_out;
    } dp_cmd_t;

endpackage

FILE: design/bsdg_if.sv
`timescale 1ns / 1ps
// Handshake channels of the brick scatter descriptor generator:
// step requests, descriptors and configuration writes. Uses bsdg_pkg.

interface bsdg_req_if;
    import bsdg_pkg::*;
    logic valid;
    logic ready;
    logic restart;
    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

interface bsdg_rsp_if;
    import bsdg_pkg::*;
    logic               valid;
    logic               ready;
    logic [DEST_W-1:0]  dest_offset;
    logic [BYTES_W-1:0] byte_count;
    logic [SRC_W-1:0]   src_offset;
    logic               last_row;
    modport source (output valid, output dest_offset, output byte_count,
                    output src_offset, output last_row, input ready);
    modport sink   (input valid, input dest_offset, input byte_count,
                    input src_offset, input last_row, output ready);
endinterface

interface bsdg_cfg_if;
    import bsdg_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [REG_IDX_W-1:0]  reg_index;
    logic [CFG_DATA_W-1:0] wr_data;
    modport source (output valid, output reg_index, output wr_data, input ready);
    modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

FILE: design/brick_scatter_descriptor_gen_unit.sv
`timescale 1ns / 1ps
// Top level of the brick scatter descriptor generator.
// Depends on bsdg_pkg, the channel interfaces, bsdg_cfg_regs, bsdg_ctrl, bsdg_datapath.

// Each step request on req yields one scatter descriptor on rsp for the next
// scanline of a brick of 4-byte elements: the scanline's byte offset in the
// row-major volume, its byte length (four times the brick width), its byte
// offset in the contiguous brick buffer, and last_row on the final scanline
// of the brick, after which the row and plane counters wrap to the start.
// Set restart in a request to begin again at the first scanline. A request
// is accepted when the block is idle and runs through a four-state sequencer:
// capture and counter advance, brick origin multiplies, plane multiply-add,
// then the volume-stride and brick-stride multiplies land in the output
// register. The block takes the next request only once the previous one has
// loaded the output register; a descriptor left waiting on rsp holds only the
// final step, so the next request is accepted and worked on meanwhile.
// Configuration writes take effect at once and are accepted every cycle;
// write them only while no request is in flight. Brick sizes are saturated to
// 1..MAX_BRICK_DIM and brick positions to MAX_BRICKS_PER_DIM - 1; the volume
// sizes are used as written and the destination offset keeps its low 50 bits.
module brick_scatter_descriptor_gen_unit #(
    parameter int MAX_BRICK_DIM      = 1024,
    parameter int MAX_BRICKS_PER_DIM = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    bsdg_req_if.sink    req,
    bsdg_rsp_if.source  rsp,
    bsdg_cfg_if.sink    cfg
);
    import bsdg_pkg::*;

    cfg_t    cfg_vals;
    dp_cmd_t cmd;

    // register file, saturated values go straight to the datapath
    bsdg_cfg_regs #(
        .MAX_BRICK_DIM      (MAX_BRICK_DIM),
        .MAX_BRICKS_PER_DIM (MAX_BRICKS_PER_DIM)
    ) u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .cfg_vals (cfg_vals)
    );

    // sequencer: owns both handshakes and drives the step commands
    bsdg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_ready (rsp.ready),
        .out_valid (rsp.valid),
        .cmd       (cmd)
    );

    // counters and offset arithmetic; restart is sampled on the capture command
    bsdg_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .cfg_vals    (cfg_vals),
        .restart     (req.restart),
        .dest_offset (rsp.dest_offset),
        .byte_count  (rsp.byte_count),
        .src_offset  (rsp.src_offset),
        .last_row    (rsp.last_row)
    );

endmodule

FILE: design/bsdg_cfg_regs.sv
`timescale 1ns / 1ps
// Configuration register file with saturation of brick sizes and positions.
// Depends on bsdg_pkg and bsdg_cfg_if.
module bsdg_cfg_regs #(
    parameter int MAX_BRICK_DIM      = 1024,
    parameter int MAX_BRICKS_PER_DIM = 64
) (
    input  logic            clk,
    input  logic            rst_n,
    bsdg_cfg_if.sink        cfg,
    output bsdg_pkg::cfg_t  cfg_vals
);
    import bsdg_pkg::*;

    localparam logic [12:0] DIM_LIMIT = 13'(MAX_BRICK_DIM);
    localparam logic [10:0] POS_LIMIT = 11'(MAX_BRICKS_PER_DIM - 1);

    logic [POS_W-1:0] pos_x_reg, pos_y_reg, pos_z_reg;
    logic [VOL_W-1:0] vol_w_reg, vol_h_reg;
    logic [DIM_W-1:0] bw_reg, bh_reg, bd_reg;
    logic             wr_en;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0)
            r = DIM_W'(1);
        else if ({2'b00, v} > DIM_LIMIT)
            r = DIM_LIMIT[DIM_W-1:0];
        else
            r = v;
        return r;
    endfunction

    function automatic logic [POS_W-1:0] clamp_pos(input logic [POS_W-1:0] v);
        logic [POS_W-1:0] r;
        if ({5'b00000, v} > POS_LIMIT)
            r = POS_LIMIT[POS_W-1:0];
        else
            r = v;
        return r;
    endfunction

    assign cfg.ready = 1'b1;
    assign wr_en     = cfg.valid & cfg.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg <= '0;
            pos_y_reg <= '0;
            pos_z_reg <= '0;
            vol_w_reg <= VOL_W'(1);
            vol_h_reg <= VOL_W'(1);
            bw_reg    <= DIM_W'(1);
            bh_reg    <= DIM_W'(1);
            bd_reg    <= DIM_W'(1);
        end
        else if (wr_en)
        begin
            unique case (cfg.reg_index)
                REG_BRICK_POS_X:   pos_x_reg <= cfg.wr_data[POS_W-1:0];
                REG_BRICK_POS_Y:   pos_y_reg <= cfg.wr_data[POS_W-1:0];
                REG_BRICK_POS_Z:   pos_z_reg <= cfg.wr_data[POS_W-1:0];
                REG_VOLUME_WIDTH:  vol_w_reg <= cfg.wr_data[VOL_W-1:0];
                REG_VOLUME_HEIGHT: vol_h_reg <= cfg.wr_data[VOL_W-1:0];
                REG_BRICK_WIDTH:   bw_reg    <= cfg.wr_data[DIM_W-1:0];
                REG_BRICK_HEIGHT:  bh_reg    <= cfg.wr_data[DIM_W-1:0];
                REG_BRICK_DEPTH:   bd_reg    <= cfg.wr_data[DIM_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        cfg_vals.pos_x = clamp_pos(pos_x_reg);
        cfg_vals.pos_y = clamp_pos(pos_y_reg);
        cfg_vals.pos_z = clamp_pos(pos_z_reg);
        cfg_vals.vol_w = vol_w_reg;
        cfg_vals.vol_h = vol_h_reg;
        cfg_vals.bw    = clamp_dim(bw_reg);
        cfg_vals.bh    = clamp_dim(bh_reg);
        cfg_vals.bd    = clamp_dim(bd_reg);
    end

endmodule

FILE: design/bsdg_ctrl.sv
`timescale 1ns / 1ps
// Sequencer of the descriptor generator: request handshake, step commands
// and the descriptor valid flag. Depends on bsdg_pkg.
module bsdg_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              out_ready,
    output logic              out_valid,
    output bsdg_pkg::dp_cmd_t cmd
);
    import bsdg_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL1 = 4'b0010,
        ST_MUL2 = 4'b0100,
        ST_MUL3 = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free  = ~out_valid_reg | out_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_MUL1;
                end
            end
            ST_MUL1:
            begin
                cmd.step1  = 1'b1;
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                cmd.step2  = 1'b1;
                state_next = ST_MUL3;
            end
            ST_MUL3:
            begin
                // hold the finished work until the output register frees up
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

FILE: design/bsdg_datapath.sv
`timescale 1ns / 1ps
// Datapath of the descriptor generator: scanline counters, the three-step
// offset multiply chain and the descriptor output register. Uses bsdg_pkg.
module bsdg_datapath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  bsdg_pkg::dp_cmd_t           cmd,
    input  bsdg_pkg::cfg_t              cfg_vals,
    input  logic                        restart,
    output logic [bsdg_pkg::DEST_W-1:0]  dest_offset,
    output logic [bsdg_pkg::BYTES_W-1:0] byte_count,
    output logic [bsdg_pkg::SRC_W-1:0]   src_offset,
    output logic                        last_row
);
    import bsdg_pkg::*;

    // scanline counters
    logic [CNT_W-1:0] row_count_reg, row_count_next;
    logic [CNT_W-1:0] plane_count_reg, plane_count_next;
    logic [CNT_W-1:0] cur_row, cur_plane;
    logic             row_wrap, plane_wrap;

    // work registers
    logic [CNT_W-1:0] row_w_reg, plane_w_reg;
    logic             last_w_reg;
    logic [16:0]      tx_reg, ty_reg, tz_reg;
    logic [20:0]      pbh_reg;
    logic [34:0]      a_reg;
    logic [21:0]      sr_reg;

    // output register
    logic [DEST_W-1:0]  dest_reg;
    logic [BYTES_W-1:0] bytes_reg;
    logic [SRC_W-1:0]   src_reg;
    logic               last_reg;

    logic [51:0] dest_full;
    logic [32:0] src_full;

    assign cur_row   = restart ? '0 : row_count_reg;
    assign cur_plane = restart ? '0 : plane_count_reg;

    assign row_wrap   = ({2'b00, cur_row} + 12'd1) >= {1'b0, cfg_vals.bh};
    assign plane_wrap = row_wrap && (({2'b00, cur_plane} + 12'd1) >= {1'b0, cfg_vals.bd});

    always_comb
    begin
        row_count_next   = row_count_reg;
        plane_count_next = plane_count_reg;
        if (cmd.capture)
        begin
            if (!row_wrap)
            begin
                row_count_next   = cur_row + CNT_W'(1);
                plane_count_next = cur_plane;
            end
            else
            begin
                row_count_next   = '0;
                plane_count_next = plane_wrap ? '0 : cur_plane + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg   <= '0;
            plane_count_reg <= '0;
        end
        else
        begin
            row_count_reg   <= row_count_next;
            plane_count_reg <= plane_count_next;
        end
    end

    // final step: volume row stride multiply and brick stride multiply
    assign dest_full = a_reg * {18'd0, cfg_vals.vol_w} + {35'd0, tx_reg};
    assign src_full  = sr_reg * {11'd0, cfg_vals.bw};

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            row_w_reg   <= cur_row;
            plane_w_reg <= cur_plane;
            last_w_reg  <= plane_wrap;
        end
        if (cmd.step1)
        begin
            tx_reg  <= {11'd0, cfg_vals.pos_x} * {6'd0, cfg_vals.bw};
            ty_reg  <= {7'd0, row_w_reg} + {11'd0, cfg_vals.pos_y} * {6'd0, cfg_vals.bh};
            tz_reg  <= {7'd0, plane_w_reg} + {11'd0, cfg_vals.pos_z} * {6'd0, cfg_vals.bd};
            pbh_reg <= {11'd0, plane_w_reg} * {10'd0, cfg_vals.bh};
        end
        if (cmd.step2)
        begin
            a_reg  <= {18'd0, tz_reg} * {18'd0, cfg_vals.vol_h} + {18'd0, ty_reg};
            sr_reg <= {1'b0, pbh_reg} + {12'd0, row_w_reg};
        end
        if (cmd.load_out)
        begin
            dest_reg  <= {dest_full[DEST_W-3:0], 2'b00};
            bytes_reg <= {cfg_vals.bw, 2'b00};
            src_reg   <= {src_full[SRC_W-3:0], 2'b00};
            last_reg  <= last_w_reg;
        end
    end

    assign dest_offset = dest_reg;
    assign byte_count  = bytes_reg;
    assign src_offset  = src_reg;
    assign last_row    = last_reg;

endmodule
